// File: sv/global_alignment_score_defines.svh
// Assertion helpers for the top-level block, which checks itself.
`ifndef GLOBAL_ALIGNMENT_SCORE_DEFINES_SVH
`define GLOBAL_ALIGNMENT_SCORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gas_pkg.sv
package gas_pkg;

    localparam int MAX_LEN = 256;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int LW      = $clog2(MAX_LEN + 1);
    localparam int SW      = 5;
    localparam int OUT_W   = 16;
    // Cells stay within +/- 2*MAX_LEN*16, so this width is enough.
    localparam int CELL_W  = $clog2(2 * MAX_LEN * 16 + 1) + 1;

    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] ACT_APPEND_A = 2'd0;
    localparam logic [1:0] ACT_APPEND_B = 2'd1;
    localparam logic [1:0] ACT_SCORE    = 2'd2;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND_A,
        OP_APPEND_B,
        OP_SCORE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] symbol;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic idle;
    } bk_status_t;

    function automatic logic signed [CELL_W-1:0] ext_score(input logic signed [SW-1:0] v);
        return {{(CELL_W - SW){v[SW-1]}}, v};
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [CELL_W-1:0] v);
        logic signed [CELL_W+OUT_W:0] w;
        w = {{(OUT_W + 1){v[CELL_W-1]}}, v};
        if (w > 32767)
            return 16'sh7fff;
        else if (w < -32768)
            return 16'sh8000;
        else
            return w[OUT_W-1:0];
    endfunction

endpackage

// File: sv/gas_front.sv
module gas_front
    import gas_pkg::*;
(
    input  logic       start,
    input  logic [1:0] action,
    input  logic [7:0] symbol,
    input  q_status_t  q_status,
    output logic       busy,
    output logic       push,
    output q_entry_t   push_entry
);

    logic take;

    assign busy = q_status.full;
    assign take = start && !q_status.full;

    always_comb
    begin
        push              = 1'b0;
        push_entry.op     = OP_SCORE;
        push_entry.symbol = symbol;
        unique case (action)
            ACT_APPEND_A:
            begin
                push          = take;
                push_entry.op = OP_APPEND_A;
            end
            ACT_APPEND_B:
            begin
                push          = take;
                push_entry.op = OP_APPEND_B;
            end
            ACT_SCORE:
            begin
                push          = take;
                push_entry.op = OP_SCORE;
            end
            // unused code: accepted and dropped
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/gas_queue.sv
module gas_queue
    import gas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t q_status
);

    q_entry_t         slot_mem [Q_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    assign q_status.full  = (count_reg == QCW'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = slot_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: sv/gas_back.sv
module gas_back
    import gas_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  q_entry_t                head,
    input  q_status_t               q_status,
    input  logic signed [SW-1:0]    match_wt,
    input  logic signed [SW-1:0]    mismatch_wt,
    input  logic signed [SW-1:0]    gap_score,
    output bk_status_t              bk_status,
    output logic                    done,
    output logic signed [OUT_W-1:0] score,
    output logic                    overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL
    } state_t;

    logic [7:0]               seq_a_mem [MAX_LEN];
    logic [7:0]               seq_b_mem [MAX_LEN];
    logic signed [CELL_W-1:0] row_mem   [MAX_LEN + 1];

    state_t                   state_reg;
    logic [LW-1:0]            len_a_reg;
    logic [LW-1:0]            len_b_reg;
    logic                     ovf_reg;
    logic [LW-1:0]            i_reg;
    logic [LW-1:0]            j_reg;
    logic signed [CELL_W-1:0] acc_reg;
    logic signed [CELL_W-1:0] edge_reg;
    logic signed [CELL_W-1:0] corner_reg;
    logic signed [CELL_W-1:0] left_reg;
    logic signed [CELL_W-1:0] row_rd_reg;
    logic [7:0]               a_rd_reg;
    logic [7:0]               b_rd_reg;
    logic                     done_reg;
    logic signed [OUT_W-1:0]  score_reg;
    logic                     overflow_reg;

    logic signed [CELL_W-1:0] g;
    logic signed [CELL_W-1:0] diag;
    logic signed [CELL_W-1:0] up;
    logic signed [CELL_W-1:0] left;
    logic signed [CELL_W-1:0] best_val;
    logic signed [CELL_W-1:0] edge_next;
    logic                     pop;
    logic                     wr_a;
    logic                     wr_b;
    logic                     row_we;
    logic [LW-1:0]            row_wa;
    logic signed [CELL_W-1:0] row_wd;
    logic                     fin;
    logic signed [CELL_W-1:0] fin_val;

    assign g         = ext_score(gap_score);
    assign diag      = corner_reg + ((a_rd_reg == b_rd_reg) ? ext_score(match_wt)
                                                            : ext_score(mismatch_wt));
    assign up        = row_rd_reg + g;
    assign left      = left_reg + g;
    assign best_val  = (diag >= up && diag >= left) ? diag : ((up >= left) ? up : left);
    assign edge_next = edge_reg + g;

    assign bk_status.pop  = pop;
    assign bk_status.idle = (state_reg == ST_IDLE);
    assign done           = done_reg;
    assign score          = score_reg;
    assign overflow       = overflow_reg;

    always_comb
    begin
        pop     = 1'b0;
        wr_a    = 1'b0;
        wr_b    = 1'b0;
        row_we  = 1'b0;
        row_wa  = j_reg;
        row_wd  = acc_reg;
        fin     = 1'b0;
        fin_val = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop  = 1'b1;
                    wr_a = (head.op == OP_APPEND_A) && (len_a_reg < LW'(MAX_LEN));
                    wr_b = (head.op == OP_APPEND_B) && (len_b_reg < LW'(MAX_LEN));
                end
            end
            ST_INIT:
            begin
                row_we  = 1'b1;
                row_wa  = j_reg;
                row_wd  = acc_reg;
                fin     = (j_reg == len_b_reg) && (len_a_reg == '0);
                fin_val = acc_reg;
            end
            ST_ROW:
            begin
                row_we  = 1'b1;
                row_wa  = '0;
                row_wd  = edge_next;
                fin     = (len_b_reg == '0) && (i_reg == len_a_reg);
                fin_val = edge_next;
            end
            ST_CELL:
            begin
                row_we  = 1'b1;
                row_wa  = j_reg;
                row_wd  = best_val;
                fin     = (j_reg == len_b_reg) && (i_reg == len_a_reg);
                fin_val = best_val;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            acc_reg      <= '0;
            edge_reg     <= '0;
            corner_reg   <= '0;
            left_reg     <= '0;
            done_reg     <= 1'b0;
            score_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (head.op)
                            OP_APPEND_A:
                            begin
                                if (wr_a)
                                    len_a_reg <= len_a_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            end
                            OP_APPEND_B:
                            begin
                                if (wr_b)
                                    len_b_reg <= len_b_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            end
                            OP_SCORE:
                            begin
                                j_reg     <= '0;
                                acc_reg   <= '0;
                                edge_reg  <= '0;
                                i_reg     <= LW'(1);
                                state_reg <= ST_INIT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                // row zero: j * gap
                ST_INIT:
                begin
                    acc_reg <= acc_reg + g;
                    j_reg   <= j_reg + 1'b1;
                    if (fin)
                        state_reg <= ST_IDLE;
                    else if (j_reg == len_b_reg)
                        state_reg <= ST_ROW;
                end
                // column zero of row i, prefetch for the first cell
                ST_ROW:
                begin
                    edge_reg   <= edge_next;
                    corner_reg <= edge_reg;
                    left_reg   <= edge_next;
                    j_reg      <= LW'(1);
                    if (len_b_reg != '0)
                        state_reg <= ST_CELL;
                    else if (fin)
                        state_reg <= ST_IDLE;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_CELL:
                begin
                    left_reg   <= best_val;
                    corner_reg <= row_rd_reg;
                    j_reg      <= j_reg + 1'b1;
                    if (j_reg == len_b_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= fin ? ST_IDLE : ST_ROW;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (fin)
            begin
                score_reg    <= sat_out(fin_val);
                overflow_reg <= ovf_reg;
                ovf_reg      <= 1'b0;
                len_a_reg    <= '0;
                len_b_reg    <= '0;
            end
        end
    end

    // symbol stores and working row; read data registered
    always_ff @(posedge clk)
    begin
        if (wr_a)
            seq_a_mem[len_a_reg[AW-1:0]] <= head.symbol;
        if (wr_b)
            seq_b_mem[len_b_reg[AW-1:0]] <= head.symbol;
        if (row_we)
            row_mem[row_wa] <= row_wd;

        if (state_reg == ST_ROW)
        begin
            a_rd_reg   <= seq_a_mem[AW'(i_reg - 1'b1)];
            b_rd_reg   <= seq_b_mem['0];
            row_rd_reg <= row_mem[LW'(1)];
        end
        else if (state_reg == ST_CELL && j_reg != len_b_reg)
        begin
            b_rd_reg   <= seq_b_mem[j_reg[AW-1:0]];
            row_rd_reg <= row_mem[j_reg + 1'b1];
        end
    end

endmodule

// File: sv/global_alignment_score.sv
// Append transactions (action 0 or 1) are taken one per cycle while busy is
// low and land in the symbol stores at the edge that pops them from a
// four-entry command queue once the compute side is idle; busy is high only
// while that queue is full. A score request (action 2) occupies the compute
// side from its pop: it writes row zero, then each further row, column zero
// first. The recurrence fills one matrix cell per cycle through the single
// write and single read port of the working-row memory. The result shows on
// score and overflow, with done high for a single cycle, the cycle after the
// last cell; the receiver cannot stall, so it must capture it then. Each
// score request clears both sequences and the overflow flag. Symbols past
// 256 per sequence are dropped and flagged in the next result.
`include "global_alignment_score_defines.svh"

module global_alignment_score
    import gas_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              action,
    input  logic [7:0]              symbol,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [SW-1:0]           cfg_data,
    output logic                    done,
    output logic signed [OUT_W-1:0] score,
    output logic                    overflow
);

    logic signed [SW-1:0] match_reg;
    logic signed [SW-1:0] mismatch_reg;
    logic signed [SW-1:0] gap_reg;

    logic       push;
    q_entry_t   push_entry;
    q_entry_t   head;
    q_status_t  q_status;
    bk_status_t bk_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= 5'sd1;
            mismatch_reg <= -5'sd1;
            gap_reg      <= -5'sd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATCH:    match_reg    <= cfg_data;
                REG_MISMATCH: mismatch_reg <= cfg_data;
                REG_GAP:      gap_reg      <= cfg_data;
                default:
                begin
                    match_reg <= match_reg;
                end
            endcase
        end
    end

    gas_front u_front (
        .start      (start),
        .action     (action),
        .symbol     (symbol),
        .q_status   (q_status),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    gas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (bk_status.pop),
        .head       (head),
        .q_status   (q_status)
    );

    gas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .match_wt    (match_reg),
        .mismatch_wt (mismatch_reg),
        .gap_score   (gap_reg),
        .bk_status   (bk_status),
        .done        (done),
        .score       (score),
        .overflow    (overflow)
    );

    `GAS_ASSERT_NEXT(a_done_single, done, !done, "results closer than two cycles")
    `GAS_ASSERT_NOW(a_pop_nonempty, bk_status.pop, !q_status.empty, "pop from empty queue")
    `GAS_ASSERT_NEXT(a_push_lands, push, !q_status.empty, "pushed transaction lost")
    `GAS_ASSERT_NOW(a_done_from_compute, done, !$past(bk_status.idle), "result without compute")

endmodule
